// ===== design/fpmc_pkg.sv =====
// shared types and constants for the fence position mode controller
package fpmc_pkg;
    localparam int VAL_MAX     = 9999;
    localparam int ZERO_OFFSET = 500;
    localparam int DEF_SLOTS   = 8;
    localparam logic [9:0] PPM_RESET = 10'd100;

    localparam logic [2:0] M_SEL   = 3'd0;
    localparam logic [2:0] M_READY = 3'd1;
    localparam logic [2:0] M_PGM   = 3'd2;
    localparam logic [2:0] M_RUN   = 3'd3;
    localparam logic [2:0] M_STOP  = 3'd4;
    localparam logic [2:0] M_DMM   = 3'd5;

    localparam int K_STOP  = 0;
    localparam int K_LIMIT = 1;
    localparam int K_DONE  = 2;
    localparam int K_I     = 3;
    localparam int K_II    = 4;
    localparam int K_ZERO  = 5;
    localparam int K_UP    = 6;
    localparam int K_DOWN  = 7;
    localparam int K_MUP   = 8;
    localparam int K_MDOWN = 9;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, start divide
        logic div_step; // one restoring divide step
        logic decide;   // run the event logic, start multiply
        logic mul_step; // one shift-add multiply step
        logic finish;   // saturate and publish result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_mul;
    } t_sts;
endpackage

// ===== design/fence_position_mode_controller_unit.sv =====
// top level of the fence position mode controller
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | key, motor, limit and meter fields
//  output  | out       | o_valid / i_stall  | mode, position, target, slot, commands
//  config  | in        | i_cfg_valid / o_cfg_ready | pulses_per_mm
// a request runs 24 restoring divide steps for the pulse count, a decide step,
// 10 shift-add multiply steps when a move starts, and an output step that waits
// while a held result stalls it. one request in flight at a time.
// reset is synchronous, active low; slot store and axis state clear at once.
// the result register holds while i_stall is high.
module fence_position_mode_controller_unit #(
    parameter int NUM_SLOTS = fpmc_pkg::DEF_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [9:0]         i_key_flags,
    input  logic               i_motor_running,
    input  logic               i_motor_dir_up,
    input  logic [23:0]        i_pulses_done,
    input  logic               i_up_limit_clear,
    input  logic               i_down_limit_clear,
    input  logic               i_interlock_clear,
    input  logic               i_meter_timer_active,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_mode_now,
    output logic signed [15:0] o_position_mm,
    output logic [13:0]        o_target_mm,
    output logic [2:0]         o_slot_index,
    output logic [13:0]        o_slot_value,
    output logic               o_move_start,
    output logic signed [24:0] o_move_pulses,
    output logic               o_move_stop,
    output logic               o_slot_save,
    output logic               o_meter_timer_start,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [9:0]         i_cfg_data
);
    import fpmc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fpmc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_in_stall(o_stall),
        .o_valid(o_valid), .i_out_stall(i_stall), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    fpmc_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_key_flags(i_key_flags), .i_motor_running(i_motor_running),
        .i_motor_dir_up(i_motor_dir_up), .i_pulses_done(i_pulses_done),
        .i_up_limit_clear(i_up_limit_clear), .i_down_limit_clear(i_down_limit_clear),
        .i_interlock_clear(i_interlock_clear),
        .i_meter_timer_active(i_meter_timer_active),
        .o_mode_now(o_mode_now), .o_position_mm(o_position_mm),
        .o_target_mm(o_target_mm), .o_slot_index(o_slot_index),
        .o_slot_value(o_slot_value), .o_move_start(o_move_start),
        .o_move_pulses(o_move_pulses), .o_move_stop(o_move_stop),
        .o_slot_save(o_slot_save), .o_meter_timer_start(o_meter_timer_start)
    );

    // a new request is never taken while a result waits
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall) else $error("request taken over held result");

    // a taken request cannot produce a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid)) else $error("result too early");

    // no move count without a start
    a_pulses_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_move_start) |-> (o_move_pulses == '0))
        else $error("move count without start");
endmodule

// ===== design/fpmc_ctrl.sv =====
// sequencer for divide, decide and multiply phases
module fpmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_in_stall,
    output logic           o_valid,
    input  logic           i_out_stall,
    input  fpmc_pkg::t_sts i_sts,
    output fpmc_pkg::t_cmd o_cmd
);
    import fpmc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_valid, n_valid;
    logic       w_take;

    assign o_in_stall = (r_state != S_IDLE) || (r_valid && i_out_stall);
    assign w_take = i_valid && !o_in_stall;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_valid = r_valid && i_out_stall;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV;
                    n_cnt = 5'd0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd23) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_cnt = 5'd0;
                n_state = i_sts.need_mul ? S_MUL : S_FIN;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd9) n_state = S_FIN;
            end
            S_FIN: begin
                if (!(r_valid && i_out_stall)) begin
                    o_cmd.finish = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_valid <= n_valid;
        end
    end
endmodule

// ===== design/fpmc_dp.sv =====
// datapath: axis state, slot store, divider and multiplier
module fpmc_dp #(
    parameter int NUM_SLOTS = fpmc_pkg::DEF_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpmc_pkg::t_cmd     i_cmd,
    output fpmc_pkg::t_sts     o_sts,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_data,
    input  logic [9:0]         i_key_flags,
    input  logic               i_motor_running,
    input  logic               i_motor_dir_up,
    input  logic [23:0]        i_pulses_done,
    input  logic               i_up_limit_clear,
    input  logic               i_down_limit_clear,
    input  logic               i_interlock_clear,
    input  logic               i_meter_timer_active,
    output logic [2:0]         o_mode_now,
    output logic signed [15:0] o_position_mm,
    output logic [13:0]        o_target_mm,
    output logic [2:0]         o_slot_index,
    output logic [13:0]        o_slot_value,
    output logic               o_move_start,
    output logic signed [24:0] o_move_pulses,
    output logic               o_move_stop,
    output logic               o_slot_save,
    output logic               o_meter_timer_start
);
    import fpmc_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);

    logic [9:0]  r_ppm;
    logic [2:0]  r_mode;
    logic [15:0] r_pos, r_base;
    logic [13:0] r_tgt, r_edit;
    logic        r_zero;
    logic [SW-1:0] r_slot;
    logic [13:0] r_store [NUM_SLOTS];

    // captured request
    logic [9:0]  r_keys;
    logic        r_run, r_dir, r_up_ok, r_dn_ok, r_meter;
    // divider
    logic [23:0] r_quo;
    logic [9:0]  r_rem;
    // multiplier
    logic [15:0] r_diff_mag;   // |target - base|, 17-bit signed fits as magnitude
    logic        r_diff_neg;
    logic [26:0] r_acc;
    logic [9:0]  r_mcand;
    // pending flags
    logic r_start, r_stop, r_save, r_mstart;

    logic [9:0] w_ppm;
    assign w_ppm = (r_ppm == '0) ? 10'd1 : r_ppm;

    // divide step
    logic [10:0] w_trial;
    logic [10:0] w_sub;
    assign w_trial = {r_rem, r_quo[23]};
    assign w_sub = w_trial - {1'b0, w_ppm};

    // event logic
    logic [2:0]  d_mode;
    logic [15:0] d_pos, d_base;
    logic [13:0] d_tgt, d_edit;
    logic        d_zero, d_stop, d_save, d_mstart, d_start, d_meter;
    logic [SW-1:0] d_slot;
    logic [SW-1:0] d_wr_slot;
    logic [13:0] d_store_wr;
    logic        d_store_we;
    logic signed [16:0] d_diff;
    logic signed [16:0] w_pos_s;
    logic [13:0] w_rd;

    always_comb begin
        d_mode = r_mode; d_pos = r_pos; d_base = r_base; d_tgt = r_tgt;
        d_edit = r_edit; d_zero = r_zero; d_slot = r_slot;
        d_stop = 1'b0; d_save = 1'b0; d_mstart = 1'b0; d_start = 1'b0;
        d_meter = r_meter; d_store_we = 1'b0; d_store_wr = r_edit;
        d_wr_slot = '0;
        w_pos_s = '0; w_rd = '0; d_diff = '0;

        if (32'(d_slot) >= NUM_SLOTS) d_slot = '0;
        if (r_run) d_pos = r_dir ? r_base + r_quo[15:0] : r_base - r_quo[15:0];

        if (r_keys[K_STOP] && d_mode == M_READY) begin
            d_mode = M_DMM; d_meter = 1'b1; d_mstart = 1'b1;
        end
        if (d_mode == M_DMM && !d_meter) d_mode = M_READY;

        if ((r_keys[K_STOP] || r_keys[K_LIMIT]) && d_mode == M_RUN) begin
            d_stop = 1'b1;
            d_mode = r_keys[K_STOP] ? M_READY : M_STOP;
            d_base = d_pos;
            w_pos_s = 17'(signed'(d_pos));
            if (w_pos_s < 0) d_tgt = '0;
            else if (w_pos_s > VAL_MAX) d_tgt = 14'(VAL_MAX);
            else d_tgt = d_pos[13:0];
            if (r_zero) begin
                d_base = '0; d_pos = '0; d_tgt = '0; d_zero = 1'b0; d_mode = M_READY;
            end
        end

        if (r_keys[K_DONE] && d_mode == M_RUN) begin
            d_mode = M_READY;
            d_base = {2'b00, d_tgt};
            d_pos = {2'b00, d_tgt};
        end

        if (d_mode != M_RUN) begin
            w_rd = r_store[d_slot];
            if (r_keys[K_I]) begin
                d_mode = (d_mode == M_SEL) ? M_READY : M_SEL;
                d_edit = w_rd;
            end else if (r_keys[K_II]) begin
                if (d_mode == M_PGM) begin
                    d_store_we = 1'b1; d_store_wr = d_edit; d_wr_slot = d_slot;
                    d_save = 1'b1; d_mode = M_SEL;
                end else begin
                    d_mode = M_PGM; d_edit = w_rd;
                end
            end else if (r_keys[K_ZERO] && d_mode == M_READY && r_dn_ok) begin
                d_pos = 16'(ZERO_OFFSET); d_base = 16'(ZERO_OFFSET);
                d_tgt = '0; d_zero = 1'b1;
            end

            if (d_mode == M_PGM && r_keys[K_UP] && d_edit < 14'(VAL_MAX))
                d_edit = d_edit + 14'd1;
            else if (d_mode == M_PGM && r_keys[K_DOWN] && d_edit > 14'd0)
                d_edit = d_edit - 14'd1;

            // a slot saved in this request reads back its new value
            if (d_mode == M_SEL && r_keys[K_UP]) begin
                d_slot = (d_slot < SLOT_LAST) ? d_slot + SW'(1) : '0;
                d_edit = (d_store_we && d_slot == d_wr_slot) ? d_store_wr : r_store[d_slot];
            end else if (d_mode == M_SEL && r_keys[K_DOWN]) begin
                d_slot = (d_slot > '0) ? d_slot - SW'(1) : SLOT_LAST;
                d_edit = (d_store_we && d_slot == d_wr_slot) ? d_store_wr : r_store[d_slot];
            end

            if (d_mode == M_READY && r_keys[K_UP] && r_up_ok) begin
                if ({1'b0, d_tgt} < 15'(VAL_MAX) - {1'b0, d_edit}) d_tgt = d_tgt + d_edit;
            end else if (d_mode == M_READY && r_keys[K_DOWN] && r_dn_ok) begin
                if (d_tgt >= d_edit) d_tgt = d_tgt - d_edit;
            end

            if (r_keys[K_MUP] && d_tgt < 14'(VAL_MAX) && d_mode == M_READY && r_up_ok)
                d_tgt = d_tgt + 14'd1;
            else if (r_keys[K_MDOWN] && d_tgt > 14'd0 && d_mode == M_READY && r_dn_ok)
                d_tgt = d_tgt - 14'd1;
        end

        d_diff = signed'({3'b000, d_tgt}) - 17'(signed'(d_base));
        if (d_diff != 17'sd0 && d_mode == M_READY) begin
            d_start = 1'b1; d_mode = M_RUN;
        end
    end

    assign o_sts.need_mul = d_start;

    logic signed [27:0] w_signed;
    assign w_signed = r_diff_neg ? -signed'({1'b0, r_acc}) : signed'({1'b0, r_acc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm <= PPM_RESET;
            r_mode <= M_SEL; r_pos <= '0; r_base <= '0; r_tgt <= '0;
            r_zero <= 1'b0; r_slot <= '0; r_edit <= '0;
        end else begin
            if (i_cfg_we) r_ppm <= i_cfg_data;
            if (i_cmd.decide) begin
                r_mode <= d_mode; r_pos <= d_pos; r_base <= d_base; r_tgt <= d_tgt;
                r_zero <= d_zero; r_slot <= d_slot; r_edit <= d_edit;
            end
        end
    end

    // slot store: cleared by reset, small register array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) r_store[i] <= '0;
        end else if (i_cmd.decide && d_store_we) begin
            r_store[d_wr_slot] <= d_store_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_keys <= i_key_flags; r_run <= i_motor_running; r_dir <= i_motor_dir_up;
            r_up_ok <= i_up_limit_clear && i_interlock_clear;
            r_dn_ok <= i_down_limit_clear && i_interlock_clear;
            r_meter <= i_meter_timer_active;
            r_quo <= i_pulses_done; r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_sub[10]) begin
                r_rem <= w_sub[9:0]; r_quo <= {r_quo[22:0], 1'b1};
            end else begin
                r_rem <= w_trial[9:0]; r_quo <= {r_quo[22:0], 1'b0};
            end
        end
        if (i_cmd.decide) begin
            r_start <= d_start; r_stop <= d_stop; r_save <= d_save; r_mstart <= d_mstart;
            r_diff_neg <= d_diff[16];
            r_diff_mag <= d_diff[16] ? 16'(-d_diff) : d_diff[15:0];
            r_acc <= '0; r_mcand <= w_ppm;
        end
        if (i_cmd.mul_step) begin
            r_acc <= (r_acc << 1) + (r_mcand[9] ? {11'd0, r_diff_mag} : 27'd0);
            r_mcand <= {r_mcand[8:0], 1'b0};
        end
        if (i_cmd.finish) begin
            o_mode_now <= r_mode;
            o_position_mm <= signed'(r_pos);
            o_target_mm <= r_tgt;
            o_slot_index <= 3'(r_slot);
            o_slot_value <= r_edit;
            o_move_start <= r_start;
            o_move_stop <= r_stop;
            o_slot_save <= r_save;
            o_meter_timer_start <= r_mstart;
            if (!r_start) o_move_pulses <= '0;
            else if (w_signed > 28'sd16777215) o_move_pulses <= 25'sd16777215;
            else if (w_signed < -28'sd16777216) o_move_pulses <= -25'sd16777216;
            else o_move_pulses <= w_signed[24:0];
        end
    end
endmodule

// ===== tb/tb_fence_position_mode_controller_unit.sv =====
// self-checking testbench for the fence position mode controller
`timescale 1ns / 1ps

module tb_fence_position_mode_controller_unit;
    import fpmc_pkg::*;

    localparam int NSLOT       = DEF_SLOTS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_RANDOM    = 1800;
    localparam int N_CALM      = 200;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic [9:0]  keys;
        logic        running;
        logic        dir_up;
        logic [23:0] pulses;
        logic        up_clr;
        logic        down_clr;
        logic        lock_clr;
        logic        meter_on;
    } event_t;

    typedef struct {
        logic [2:0]         mode;
        logic signed [15:0] pos;
        logic [13:0]        target;
        logic [2:0]         slot;
        logic [13:0]        value;
        logic               start;
        logic signed [24:0] pulses;
        logic               stop;
        logic               save;
        logic               mstart;
    } axis_out_t;

    typedef struct {
        event_t     ev;
        bit         typed;
        logic [2:0] mode;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [9:0] i_key_flags = '0;
    logic i_motor_running = 1'b0;
    logic i_motor_dir_up = 1'b0;
    logic [23:0] i_pulses_done = '0;
    logic i_up_limit_clear = 1'b0;
    logic i_down_limit_clear = 1'b0;
    logic i_interlock_clear = 1'b0;
    logic i_meter_timer_active = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_mode_now;
    logic signed [15:0] o_position_mm;
    logic [13:0] o_target_mm;
    logic [2:0] o_slot_index;
    logic [13:0] o_slot_value;
    logic o_move_start;
    logic signed [24:0] o_move_pulses;
    logic o_move_stop;
    logic o_slot_save;
    logic o_meter_timer_start;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [9:0] i_cfg_data = '0;

    fence_position_mode_controller_unit #(.NUM_SLOTS(NSLOT)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [9:0]  ppm_reg;
    logic [2:0]  mode_q;
    logic [15:0] pos_q;
    logic [15:0] base_q;
    int          target_q;
    bit          zeroing_q;
    int          slot_q;
    int          edit_q;
    int          store_q [NSLOT];

    axis_out_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_moves = 0;
    int n_cfg = 0;
    int cycles = 0;
    bit calm = 1'b0;

    function automatic int clamp9999(int v);
        if (v < 0) return 0;
        if (v > VAL_MAX) return VAL_MAX;
        return v;
    endfunction

    function automatic axis_out_t predict_axis(event_t ev);
        axis_out_t r;
        int unsigned ppm;
        int unsigned q;
        logic [31:0] step;
        bit up_ok;
        bit down_ok;
        bit meter;
        longint mp;
        ppm = (ppm_reg == 0) ? 1 : ppm_reg;
        up_ok = ev.up_clr && ev.lock_clr;
        down_ok = ev.down_clr && ev.lock_clr;
        meter = ev.meter_on;
        mp = 0;
        r = '{default: '0};
        if (slot_q >= NSLOT) slot_q = 0;
        if (ev.running) begin
            q = ev.pulses / ppm;
            step = ev.dir_up ? q : (32'd0 - q);
            pos_q = base_q + step[15:0];
        end
        if (ev.keys[K_STOP] && mode_q == M_READY) begin
            mode_q = M_DMM;
            meter = 1'b1;
            r.mstart = 1'b1;
        end
        if (mode_q == M_DMM && !meter) mode_q = M_READY;
        if ((ev.keys[K_STOP] || ev.keys[K_LIMIT]) && mode_q == M_RUN) begin
            r.stop = 1'b1;
            mode_q = ev.keys[K_STOP] ? M_READY : M_STOP;
            base_q = pos_q;
            target_q = clamp9999(int'($signed(pos_q)));
            if (zeroing_q) begin
                base_q = '0;
                pos_q = '0;
                target_q = 0;
                zeroing_q = 1'b0;
                mode_q = M_READY;
            end
        end
        if (ev.keys[K_DONE] && mode_q == M_RUN) begin
            mode_q = M_READY;
            base_q = target_q[15:0];
            pos_q = target_q[15:0];
        end
        if (mode_q != M_RUN) begin
            if (ev.keys[K_I]) begin
                mode_q = (mode_q == M_SEL) ? M_READY : M_SEL;
                edit_q = store_q[slot_q];
            end else if (ev.keys[K_II]) begin
                if (mode_q == M_PGM) begin
                    store_q[slot_q] = edit_q;
                    r.save = 1'b1;
                    mode_q = M_SEL;
                end else begin
                    mode_q = M_PGM;
                    edit_q = store_q[slot_q];
                end
            end else if (ev.keys[K_ZERO] && mode_q == M_READY && down_ok) begin
                pos_q = 16'(ZERO_OFFSET);
                base_q = 16'(ZERO_OFFSET);
                target_q = 0;
                zeroing_q = 1'b1;
            end
            if (mode_q == M_PGM && ev.keys[K_UP] && edit_q < VAL_MAX) edit_q++;
            else if (mode_q == M_PGM && ev.keys[K_DOWN] && edit_q > 0) edit_q--;
            if (mode_q == M_SEL && ev.keys[K_UP]) begin
                slot_q = (slot_q < NSLOT - 1) ? slot_q + 1 : 0;
                edit_q = store_q[slot_q];
            end else if (mode_q == M_SEL && ev.keys[K_DOWN]) begin
                slot_q = (slot_q > 0) ? slot_q - 1 : NSLOT - 1;
                edit_q = store_q[slot_q];
            end
            if (mode_q == M_READY && ev.keys[K_UP] && up_ok) begin
                if (target_q < VAL_MAX - edit_q) target_q += edit_q;
            end else if (mode_q == M_READY && ev.keys[K_DOWN] && down_ok) begin
                if (target_q >= edit_q) target_q -= edit_q;
            end
            if (ev.keys[K_MUP] && target_q < VAL_MAX && mode_q == M_READY && up_ok)
                target_q++;
            else if (ev.keys[K_MDOWN] && target_q > 0 && mode_q == M_READY && down_ok)
                target_q--;
        end
        if (int'($signed(base_q)) != target_q && mode_q == M_READY) begin
            mp = longint'(target_q - int'($signed(base_q))) * longint'(ppm);
            if (mp > 16777215) mp = 16777215;
            if (mp < -16777216) mp = -16777216;
            r.start = 1'b1;
            mode_q = M_RUN;
        end
        r.mode = mode_q;
        r.pos = pos_q;
        r.target = target_q[13:0];
        r.slot = slot_q[2:0];
        r.value = edit_q[13:0];
        r.pulses = mp[24:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // output checker
    always @(posedge i_clk) begin
        axis_out_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("[%0t] result with no request outstanding", $time);
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (o_mode_now !== e.mode) report_mismatch("mode", o_mode_now, e.mode);
                if (o_position_mm !== e.pos) report_mismatch("position", o_position_mm, e.pos);
                if (o_target_mm !== e.target) report_mismatch("target", o_target_mm, e.target);
                if (o_slot_index !== e.slot) report_mismatch("slot", o_slot_index, e.slot);
                if (o_slot_value !== e.value) report_mismatch("value", o_slot_value, e.value);
                if (o_move_start !== e.start) report_mismatch("start", o_move_start, e.start);
                if (o_move_pulses !== e.pulses)
                    report_mismatch("pulses", o_move_pulses, e.pulses);
                if (o_move_stop !== e.stop) report_mismatch("stop", o_move_stop, e.stop);
                if (o_slot_save !== e.save) report_mismatch("save", o_slot_save, e.save);
                if (o_meter_timer_start !== e.mstart)
                    report_mismatch("meter start", o_meter_timer_start, e.mstart);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver backpressure, with one long hold-off to fill the block
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!held && n_checked >= 150) begin
                held = 1'b1;
                i_stall <= 1'b1;
                for (n = 0; n < 400; n++) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
                n = $urandom_range(1, 13);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(event_t ev, bit typed, logic [2:0] mode);
        axis_out_t r;
        if (!calm && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key_flags <= ev.keys;
        i_motor_running <= ev.running;
        i_motor_dir_up <= ev.dir_up;
        i_pulses_done <= ev.pulses;
        i_up_limit_clear <= ev.up_clr;
        i_down_limit_clear <= ev.down_clr;
        i_interlock_clear <= ev.lock_clr;
        i_meter_timer_active <= ev.meter_on;
        do @(posedge i_clk); while (o_stall);
        r = predict_axis(ev);
        if (typed) r.mode = mode;
        if (r.start) n_moves++;
        expected_q.push_back(r);
        n_sent++;
    endtask

    task automatic write_ppm(logic [9:0] v);
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ppm_reg = v;
        n_cfg++;
    endtask

    function automatic event_t mk(logic [9:0] keys, logic run, logic up, logic [23:0] p,
                                  logic [2:0] lims, logic meter);
        event_t ev;
        ev.keys = keys;
        ev.running = run;
        ev.dir_up = up;
        ev.pulses = p;
        {ev.up_clr, ev.down_clr, ev.lock_clr} = lims;
        ev.meter_on = meter;
        return ev;
    endfunction

    function automatic event_t random_event();
        event_t ev;
        int k;
        k = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 7) ev.keys = 10'd1 << k;
        else if ($urandom_range(0, 1) == 0) ev.keys = '0;
        else ev.keys = 10'($urandom_range(0, 1023));
        ev.running = 1'($urandom_range(0, 1));
        ev.dir_up = 1'($urandom_range(0, 1));
        ev.pulses = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                : 24'($urandom_range(0, 20000));
        ev.up_clr = ($urandom_range(0, 7) != 0);
        ev.down_clr = ($urandom_range(0, 7) != 0);
        ev.lock_clr = ($urandom_range(0, 7) != 0);
        ev.meter_on = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    initial begin
        row_t rows[$];
        logic [9:0] ppm_plan[6];
        int i;
        int ph;
        ppm_reg = PPM_RESET;
        mode_q = M_SEL;
        pos_q = '0;
        base_q = '0;
        target_q = 0;
        zeroing_q = 1'b0;
        slot_q = 0;
        edit_q = 0;
        foreach (store_q[j]) store_q[j] = 0;

        rows = '{
            '{mk(10'h000, 0, 0, 0, 3'b111, 0), 1, M_SEL},
            '{mk(10'h040, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h080, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h080, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h010, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h040, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h010, 0, 0, 0, 3'b111, 0), 1, M_SEL},
            '{mk(10'h008, 0, 0, 0, 3'b111, 0), 1, M_READY},
            '{mk(10'h040, 0, 0, 0, 3'b111, 0), 1, M_RUN},
            '{mk(10'h001, 1, 1, 50, 3'b111, 0), 1, M_READY},
            '{mk(10'h100, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h002, 1, 0, 24'hFFFFFF, 3'b111, 0), 0, M_SEL},
            '{mk(10'h008, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h008, 0, 0, 0, 3'b111, 0), 0, M_SEL},
            '{mk(10'h004, 1, 1, 24'hFFFFFF, 3'b111, 1), 0, M_SEL},
            '{mk(10'h001, 0, 0, 0, 3'b111, 0), 1, M_DMM},
            '{mk(10'h000, 0, 0, 0, 3'b111, 0), 1, M_READY},
            '{mk(10'h020, 0, 0, 0, 3'b111, 0), 1, M_RUN},
            '{mk(10'h002, 1, 0, 300, 3'b111, 0), 1, M_READY},
            '{mk(10'h200, 0, 0, 0, 3'b110, 0), 0, M_SEL},
            '{mk(10'h200, 0, 0, 0, 3'b011, 0), 0, M_SEL},
            '{mk(10'h3FF, 1, 1, 24'hABCDEF, 3'b111, 1), 0, M_SEL},
            '{mk(10'h3FF, 0, 0, 24'h543210, 3'b000, 0), 0, M_SEL}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_event(rows[r].ev, rows[r].typed, rows[r].mode);

        // pulses per mm settings, zero is treated as one
        ppm_plan = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'($urandom_range(2, 999)), PPM_RESET};
        for (ph = 0; ph < 6; ph++) begin
            write_ppm(ppm_plan[ph]);
            for (i = 0; i < N_RANDOM / 6; i++) begin
                if (ph == 5 && i >= N_RANDOM / 6 - N_CALM) calm = 1'b1;
                send_event(random_event(), 1'b0, M_SEL);
            end
        end
        i_valid <= 1'b0;
        calm = 1'b1;

        wait (expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d events, checked %0d results, %0d moves started, %0d ppm writes",
                 n_sent, n_checked, n_moves, n_cfg);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
